// ===== design/iracc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iracc_pkg
// Shared types and constants for the information ratio accumulator.
// ----------------------------------------------------------------------------
package iracc_pkg;

    localparam int unsigned MaxSamples = 4096;
    localparam int unsigned CntW       = 13;
    localparam int unsigned SumW       = 38;
    localparam int unsigned SqW        = 61;
    localparam int unsigned RetW       = 24;
    localparam int unsigned FacW       = 24;
    localparam int unsigned RootW      = 54;
    localparam int unsigned NumW       = 128;
    localparam logic [FacW-1:0] FactorReset = 24'd1040352;
    localparam logic [CntW-1:0] MaxCount = CntW'(MaxSamples);
    localparam logic [1:0] RegFactor = 2'd0;

    // one finished group handed from the front to the back
    typedef struct packed {
        logic signed [SumW-1:0] sum;
        logic [SqW-1:0]         sumsq;
        logic [CntW-1:0]        count;
        logic                   dropped;
    } grp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage
`default_nettype wire

// ===== design/information_ratio_accumulator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// information_ratio_accumulator_core
// Annualized information ratio over groups of asset/benchmark return pairs.
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle; each group's final transfer hands the sums
// to a one-entry queue and a sequential back end that works each group
// through shift-add multiplies of up to 13, 36 and 24 steps, a 54-step
// square root and a 128-step division, each with a hand-over in between;
// groups with zero deviation finish early. Input stalls, for every transfer,
// while a finished group sits in the queue and the back end has not yet
// taken it, i.e. while the back end is still busy with the previous group
// or holds a result that has not been taken. Register 0 at byte address 0
// holds the Q8.16 annualization factor.
module information_ratio_accumulator_core
    import iracc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [1:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [RetW-1:0] asset_return,
    input  wire logic signed [RetW-1:0] bench_return,
    input  wire logic                   asset_present,
    input  wire logic                   bench_present,
    input  wire logic                   last_sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [31:0]          ratio,
    output logic                        ratio_valid,
    output logic [CntW-1:0]             samples_used,
    output logic                        count_saturated
);

    logic [FacW-1:0] factor_reg;
    logic            q_valid;
    logic            q_ready;
    grp_t            q_data;

    assign pready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            factor_reg <= FactorReset;
        else if (psel && penable && pwrite && paddr == RegFactor)
            factor_reg <= pwdata[FacW-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == RegFactor)
            prdata = 32'(factor_reg);
    end

    iracc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .asset_return  (asset_return),
        .bench_return  (bench_return),
        .asset_present (asset_present),
        .bench_present (bench_present),
        .last_sample   (last_sample),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_data        (q_data)
    );

    iracc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_data          (q_data),
        .factor          (factor_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ratio           (ratio),
        .ratio_valid     (ratio_valid),
        .samples_used    (samples_used),
        .count_saturated (count_saturated)
    );

endmodule
`default_nettype wire

// ===== design/iracc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iracc_front
// Accepts return pairs, accumulates excess sums and hands groups to a queue.
// ----------------------------------------------------------------------------
module iracc_front
    import iracc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [RetW-1:0] asset_return,
    input  wire logic signed [RetW-1:0] bench_return,
    input  wire logic                   asset_present,
    input  wire logic                   bench_present,
    input  wire logic                   last_sample,
    output logic                        q_valid,
    input  wire logic                   q_ready,
    output grp_t                        q_data
);

    logic signed [SumW-1:0] sum_reg;
    logic [SqW-1:0]         sq_reg;
    logic [CntW-1:0]        cnt_reg;
    logic                   drop_reg;
    logic                   full_reg;
    grp_t                   slot_reg;

    logic signed [RetW:0]   exc;
    logic [RetW:0]          mag;
    logic [2*RetW+1:0]      sqr;
    logic                   take;
    logic                   use_pair;
    logic                   drop_pair;
    grp_t                   fin;

    // single-entry queue; accept while slot free or draining
    assign in_ready = !full_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign q_valid  = full_reg;
    assign q_data   = slot_reg;

    // excess and its square
    always_comb
    begin
        exc       = (RetW+1)'(asset_return) - (RetW+1)'(bench_return);
        mag       = exc[RetW] ? -exc : exc;
        sqr       = mag * mag;
        use_pair  = asset_present && bench_present && (cnt_reg < MaxCount);
        drop_pair = asset_present && bench_present && !(cnt_reg < MaxCount);
        fin.sum     = use_pair ? sum_reg + SumW'(exc) : sum_reg;
        fin.sumsq   = use_pair ? sq_reg + SqW'(sqr) : sq_reg;
        fin.count   = use_pair ? cnt_reg + 1'b1 : cnt_reg;
        fin.dropped = drop_reg || drop_pair;
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            sq_reg   <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (last_sample)
                begin
                    sum_reg  <= '0;
                    sq_reg   <= '0;
                    cnt_reg  <= '0;
                    drop_reg <= 1'b0;
                end
                else
                begin
                    sum_reg  <= fin.sum;
                    sq_reg   <= fin.sumsq;
                    cnt_reg  <= fin.count;
                    drop_reg <= fin.dropped;
                end
            end
            if (take && last_sample)
                full_reg <= 1'b1;
            else if (q_ready)
                full_reg <= 1'b0;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (take && last_sample)
            slot_reg <= fin;
    end

endmodule
`default_nettype wire

// ===== design/iracc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iracc_back
// Finishes one group: variance, bit-serial square root and division.
// ----------------------------------------------------------------------------
module iracc_back
    import iracc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire grp_t               q_data,
    input  wire logic [FacW-1:0]    factor,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      ratio,
    output logic                    ratio_valid,
    output logic [CntW-1:0]         samples_used,
    output logic                    count_saturated
);

    back_state_t state_reg, state_next;
    logic [6:0]  step_reg, step_next;
    grp_t        grp_reg;
    logic [FacW-1:0] fac_reg;

    logic [NumW-1:0]  x_reg, x_next;       // radicand, later numerator
    logic [RootW-1:0] r_reg, r_next;       // root
    logic [NumW-1:0]  rem_reg, rem_next;   // remainder of root / division
    logic [32:0]      q_reg, q_next;
    logic [1:0]       mstep_reg, mstep_next;
    logic [NumW-1:0]  acc_reg, acc_next;
    logic [NumW-1:0]  mcand_reg, mcand_next;
    logic [SumW-1:0]  mplier_reg, mplier_next;
    logic [SumW-1:0]  mag_reg;

    logic             out_valid_reg;
    logic [31:0]      ratio_reg;
    logic             rv_reg;
    logic [CntW-1:0]  su_reg;
    logic             cs_reg;

    logic [NumW-1:0]  trial;
    logic [NumW-1:0]  rsh;
    logic [NumW-1:0]  drem;
    logic [32:0]      qsh;
    logic [31:0]      res;

    assign q_ready         = (state_reg == ST_IDLE) && q_valid;
    assign out_valid       = out_valid_reg;
    assign ratio           = ratio_reg;
    assign ratio_valid     = rv_reg;
    assign samples_used    = su_reg;
    assign count_saturated = cs_reg;

    // next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        r_next      = r_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        mstep_next  = mstep_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        trial       = '0;
        rsh         = '0;
        drem        = '0;
        qsh         = '0;
        res         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next  = ST_MUL;
                    mstep_next  = '0;
                    acc_next    = '0;
                    mcand_next  = NumW'(q_data.sumsq);
                    mplier_next = SumW'(q_data.count);
                end
            end
            ST_MUL:
            begin
                // shift-add multiply, one multiplier bit per cycle
                if (mplier_reg != '0)
                begin
                    if (mplier_reg[0])
                        acc_next = acc_reg + mcand_reg;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
                else
                begin
                    // step 0: n*Q done, step 1: S*S done, step 2: numerator done
                    case (mstep_reg)
                        2'd0:
                        begin
                            x_next      = acc_reg;
                            acc_next    = '0;
                            mcand_next  = NumW'(mag_reg);
                            mplier_next = mag_reg;
                            mstep_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            if (x_reg <= acc_reg)
                            begin
                                state_next = ST_DONE;
                                q_next     = '0;
                            end
                            else
                            begin
                                // scale by 2^32 and align to the top of the radicand
                                x_next     = (x_reg - acc_reg) << (32 + NumW - 2*RootW);
                                r_next     = '0;
                                rem_next   = '0;
                                step_next  = 7'(RootW - 1);
                                state_next = ST_SQRT;
                            end
                        end
                        default:
                        begin
                            x_next     = acc_reg;
                            rem_next   = '0;
                            q_next     = '0;
                            step_next  = 7'(NumW - 1);
                            state_next = ST_DIV;
                        end
                    endcase
                end
            end
            ST_SQRT:
            begin
                // restoring root: two radicand bits per step
                rsh   = {rem_reg[NumW-3:0], x_reg[NumW-1 -: 2]};
                trial = (NumW'(r_reg) << 2) | NumW'(1);
                x_next = x_reg << 2;
                if (rsh >= trial)
                begin
                    rem_next = rsh - trial;
                    r_next   = (r_reg << 1) | RootW'(1);
                end
                else
                begin
                    rem_next = rsh;
                    r_next   = r_reg << 1;
                end
                step_next = step_reg - 7'd1;
                if (step_reg == '0)
                begin
                    if (r_next == '0)
                    begin
                        state_next = ST_DONE;
                        q_next     = '0;
                    end
                    else
                    begin
                        // numerator |S| * factor * 2^16
                        acc_next    = '0;
                        mcand_next  = NumW'(mag_reg) << 16;
                        mplier_next = SumW'(fac_reg);
                        mstep_next  = 2'd2;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_DIV:
            begin
                // restoring division, quotient clipped just above 2^31
                drem   = {rem_reg[NumW-2:0], x_reg[NumW-1]};
                x_next = x_reg << 1;
                qsh    = q_reg << 1;
                if (drem >= NumW'(r_reg))
                begin
                    rem_next = drem - NumW'(r_reg);
                    qsh      = qsh | 33'd1;
                end
                else
                    rem_next = drem;
                if (qsh > 33'h080000000)
                    qsh = 33'h080000001;
                q_next    = qsh;
                step_next = step_reg - 7'd1;
                if (step_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // sign and saturation of the quotient
        if (!grp_reg.sum[SumW-1])
            res = (q_reg > 33'h07fffffff) ? 32'h7fffffff : q_reg[31:0];
        else if (q_reg >= 33'h080000000)
            res = 32'h80000000;
        else
            res = 32'(33'h100000000 - q_reg);
    end

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        x_reg      <= x_next;
        r_reg      <= r_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        mstep_reg  <= mstep_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        if (state_reg == ST_IDLE && q_valid)
        begin
            grp_reg <= q_data;
            fac_reg <= factor;
            mag_reg <= q_data.sum[SumW-1] ? -q_data.sum : q_data.sum;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        begin
            rv_reg    <= grp_reg.count >= CntW'(2);
            ratio_reg <= (grp_reg.count >= CntW'(2)) ? res : 32'd0;
            su_reg    <= grp_reg.count;
            cs_reg    <= grp_reg.dropped;
        end
    end

endmodule
`default_nettype wire
